[rtl/core/bdeq_pkg.sv]
package bdeq_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    // Largest number of entries returned by one listing.
    localparam int LIST_MAX = 16;

    // Operation codes carried by the mode field.
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

[rtl/core/bdeq_ring_mem.sv]
module bdeq_ring_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [IW-1:0]                      i_wr_addr,
    input  logic signed [bdeq_pkg::DATA_W-1:0] i_wr_data,
    input  logic [IW-1:0]                      i_rd_addr,
    output logic signed [bdeq_pkg::DATA_W-1:0] o_rd_data
);

    // Ring storage with one write port and one registered read port.
    logic signed [bdeq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [bdeq_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/bounded_double_ended_queue_core.sv]
// Bounded double-ended queue of signed 32-bit items held in a ring of DEPTH entries.
// An item is accepted at a rising edge where start is high and busy is low; i_mode
// selects list, push front, push back, pop front or pop back, and i_value is the
// item pushed. Items with a mode of 5 to 7 are dropped with no result and no change.
// Each result appears for one cycle with o_valid high, carrying o_value_res, o_status
// and o_last; o_last marks the final result of an item. The receiver cannot stall.
// Pushes: a decode step through the shared ring-index adder, then the output register;
// busy is high during the decode step only.
// Pops: decode, ring read, output load, output register.
// A listing walks the ring from the front; each entry takes an index add, a registered
// ring read and an output load. Busy stays high until the last result is loaded, and
// at most LIST_MAX results are given. No new item is taken until the last one is
// through and busy is low, since the sequencer handles one item at a time.
// A push into a full queue and a pop or listing of an empty queue give one result
// with the full or empty status and a zero value. Synchronous active-low reset empties
// the queue and returns the sequencer to idle; the ring contents are not cleared and
// are only ever read where they hold a pushed item.
module bounded_double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bdeq_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [bdeq_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    output logic signed [bdeq_pkg::DATA_W-1:0] o_value_res,
    output logic [bdeq_pkg::STAT_W-1:0]        o_status,
    output logic                               o_last
);

    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int LIST_N = (DEPTH < bdeq_pkg::LIST_MAX) ? DEPTH : bdeq_pkg::LIST_MAX;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_LADDR  = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [bdeq_pkg::MODE_W-1:0]        r_mode, n_mode;
    logic signed [bdeq_pkg::DATA_W-1:0] r_value, n_value;
    logic [IW-1:0]                      r_front, n_front;
    logic [CW-1:0]                      r_occ, n_occ;
    logic [CW-1:0]                      r_k, n_k;
    logic [CW-1:0]                      r_n, n_n;
    logic [IW-1:0]                      r_rd_addr, n_rd_addr;

    logic                               r_out_valid, n_out_valid;
    logic signed [bdeq_pkg::DATA_W-1:0] r_out_value, n_out_value;
    logic [bdeq_pkg::STAT_W-1:0]        r_out_status, n_out_status;
    logic                               r_out_last, n_out_last;

    logic                               wr_en;
    logic [IW-1:0]                      wr_addr;
    logic signed [bdeq_pkg::DATA_W-1:0] rd_data;

    // Shared ring-index adder: (front + offset) wrapped into the ring.
    logic [IW-1:0] add_off;
    logic [IW:0]   add_sum;
    logic [IW-1:0] add_res;

    logic          q_empty;
    logic          q_full;
    logic          is_pop;
    logic          list_last;

    assign q_empty   = (r_occ == '0);
    assign q_full    = (r_occ == CW'(DEPTH));
    assign is_pop    = (r_mode == bdeq_pkg::MODE_POP_FRONT) ||
                       (r_mode == bdeq_pkg::MODE_POP_BACK);
    assign list_last = ((r_k + CW'(1)) == r_n);

    always_comb begin
        add_off = '0;
        if (r_state == ST_DECODE) begin
            case (r_mode)
                bdeq_pkg::MODE_PUSH_FRONT: add_off = IW'(DEPTH - 1);
                bdeq_pkg::MODE_PUSH_BACK:  add_off = IW'(r_occ);
                bdeq_pkg::MODE_POP_FRONT:  add_off = IW'(1);
                bdeq_pkg::MODE_POP_BACK:   add_off = IW'(r_occ - CW'(1));
                default:                   add_off = '0;
            endcase
        end else begin
            add_off = IW'(r_k);
        end
        add_sum = {1'b0, r_front} + {1'b0, add_off};
        if (add_sum >= (IW + 1)'(DEPTH)) begin
            add_res = IW'(add_sum - (IW + 1)'(DEPTH));
        end else begin
            add_res = IW'(add_sum);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_value      = r_value;
        n_front      = r_front;
        n_occ        = r_occ;
        n_k          = r_k;
        n_n          = r_n;
        n_rd_addr    = r_rd_addr;
        n_out_valid  = 1'b0;
        n_out_value  = '0;
        n_out_status = bdeq_pkg::STAT_OK;
        n_out_last   = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = add_res;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_value = i_value;
                    // Modes with no meaning are dropped here without a result.
                    if (i_mode <= bdeq_pkg::MODE_POP_BACK) begin
                        n_state = ST_DECODE;
                    end
                end
            end

            ST_DECODE: begin
                case (r_mode)
                    bdeq_pkg::MODE_PUSH_FRONT, bdeq_pkg::MODE_PUSH_BACK: begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        n_state     = ST_IDLE;
                        if (q_full) begin
                            n_out_status = bdeq_pkg::STAT_FULL;
                        end else begin
                            wr_en = 1'b1;
                            n_occ = r_occ + CW'(1);
                            if (r_mode == bdeq_pkg::MODE_PUSH_FRONT) begin
                                n_front = add_res;
                            end
                        end
                    end
                    bdeq_pkg::MODE_POP_FRONT, bdeq_pkg::MODE_POP_BACK: begin
                        if (q_empty) begin
                            n_out_valid  = 1'b1;
                            n_out_last   = 1'b1;
                            n_out_status = bdeq_pkg::STAT_EMPTY;
                            n_state      = ST_IDLE;
                        end else begin
                            n_occ   = r_occ - CW'(1);
                            n_state = ST_READ;
                            if (r_mode == bdeq_pkg::MODE_POP_FRONT) begin
                                n_rd_addr = r_front;
                                n_front   = add_res;
                            end else begin
                                n_rd_addr = add_res;
                            end
                        end
                    end
                    default: begin
                        // Listing: walk from the front, capped at the result limit.
                        if (q_empty) begin
                            n_out_valid  = 1'b1;
                            n_out_last   = 1'b1;
                            n_out_status = bdeq_pkg::STAT_EMPTY;
                            n_state      = ST_IDLE;
                        end else begin
                            n_k     = '0;
                            n_n     = (r_occ < CW'(LIST_N)) ? r_occ : CW'(LIST_N);
                            n_state = ST_LADDR;
                        end
                    end
                endcase
            end

            ST_LADDR: begin
                n_rd_addr = add_res;
                n_state   = ST_READ;
            end

            ST_READ: begin
                n_state = ST_LOAD;
            end

            ST_LOAD: begin
                n_out_valid = 1'b1;
                n_out_value = rd_data;
                if (is_pop || list_last) begin
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = ST_LADDR;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_k          <= n_k;
        r_n          <= n_n;
        r_rd_addr    <= n_rd_addr;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    bdeq_ring_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default depth, and the shadow queue below
    // follows the same size.
    localparam int DEPTH = 16;

    // A listing of a full ring is the slowest item. After the last expected
    // result we wait longer than such a listing takes, so that a stray result
    // would still be caught.
    localparam int SETTLE_CYCLES = 3 * bdeq_pkg::LIST_MAX + 8;

    // The watchdog fires after this many cycles with no item accepted and no
    // result seen. The slowest legal stretch is a full listing or the settle
    // pause, both far shorter than this limit.
    localparam int WATCHDOG_LIMIT = 1000;

    // Longest run of idle cycles that the sender inserts between two items.
    localparam int MAX_GAP = 20;

    // Number of counted random items in each idling phase.
    localparam int PHASE_ITEMS = 18;

    localparam logic signed [bdeq_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(bdeq_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [bdeq_pkg::DATA_W-1:0] VAL_MAX = ~VAL_MIN;

    // One result as the block presents it.
    typedef struct {
        logic signed [bdeq_pkg::DATA_W-1:0] value;
        logic [bdeq_pkg::STAT_W-1:0]        status;
        logic                               last;
    } t_dq_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [bdeq_pkg::MODE_W-1:0]        i_mode;
    logic signed [bdeq_pkg::DATA_W-1:0] i_value;
    logic                               o_valid;
    logic signed [bdeq_pkg::DATA_W-1:0] o_value_res;
    logic [bdeq_pkg::STAT_W-1:0]        o_status;
    logic                               o_last;

    bounded_double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Shadow copy of the queue. Only the held entries are ever read, so the
    // ring needs no reset of its own.
    logic signed [bdeq_pkg::DATA_W-1:0] shadow_ring [DEPTH];
    int                                 shadow_front = 0;
    int                                 shadow_count = 0;

    // Results still owed by the block, oldest first.
    t_dq_result queue_results [$];

    int mismatches = 0;
    int idle_cycles = 0;

    // Chance in percent that the sender goes idle after each item.
    int sender_idle_pct = 0;

    // Applies one accepted item to the shadow queue and queues the results
    // that it must produce, in order.
    function automatic void apply_to_shadow(input logic [bdeq_pkg::MODE_W-1:0] mode,
                                            input logic signed [bdeq_pkg::DATA_W-1:0] value);
        int         n;
        int         pos;
        t_dq_result r;

        r.value  = '0;
        r.status = bdeq_pkg::STAT_OK;
        r.last   = 1'b1;
        case (mode)
            bdeq_pkg::MODE_LIST: begin
                if (shadow_count == 0) begin
                    r.status = bdeq_pkg::STAT_EMPTY;
                    queue_results.push_back(r);
                end else begin
                    // A listing stops at LIST_MAX entries even if more are held.
                    n = (shadow_count < bdeq_pkg::LIST_MAX) ? shadow_count
                                                            : bdeq_pkg::LIST_MAX;
                    for (int k = 0; k < n; k++) begin
                        r.value = shadow_ring[(shadow_front + k) % DEPTH];
                        r.last  = (k == n - 1);
                        queue_results.push_back(r);
                    end
                end
            end
            bdeq_pkg::MODE_PUSH_FRONT, bdeq_pkg::MODE_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    // A push into a full queue is dropped.
                    r.status = bdeq_pkg::STAT_FULL;
                end else if (mode == bdeq_pkg::MODE_PUSH_FRONT) begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_front] = value;
                    shadow_count++;
                end else begin
                    shadow_ring[(shadow_front + shadow_count) % DEPTH] = value;
                    shadow_count++;
                end
                queue_results.push_back(r);
            end
            bdeq_pkg::MODE_POP_FRONT, bdeq_pkg::MODE_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = bdeq_pkg::STAT_EMPTY;
                end else begin
                    if (mode == bdeq_pkg::MODE_POP_FRONT) begin
                        pos = shadow_front;
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end else begin
                        pos = (shadow_front + shadow_count - 1) % DEPTH;
                    end
                    shadow_count--;
                    r.value = shadow_ring[pos];
                end
                queue_results.push_back(r);
            end
            default: begin
                // Modes without a meaning are ignored by the block.
            end
        endcase
    endfunction

    // Result checker and predictor. Both sample at the rising edge, so they
    // see the values that the block itself saw at that edge. A result can
    // never belong to an item accepted at the same edge, so checking before
    // predicting is safe.
    always @(posedge i_clk) begin
        t_dq_result want;
        if (i_rst_n && o_valid) begin
            if (queue_results.size() == 0) begin
                $error("unexpected result: value_res %0d, status %0d, last %0b",
                       o_value_res, o_status, o_last);
                mismatches++;
            end else begin
                want = queue_results.pop_front();
                if (o_value_res !== want.value) begin
                    $error("value_res: expected %0d, got %0d", want.value, o_value_res);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            apply_to_shadow(i_mode, i_value);
        end
    end

    // Watchdog: any accepted item or any result counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_double_ended_queue_core regression: fail");
            $finish;
        end
    end

    // Offers one item and returns once the block has taken it. Start stays
    // high into the next item unless the sender decides to go idle, in which
    // case it is lowered once for the whole gap.
    task automatic issue_op(input logic [bdeq_pkg::MODE_W-1:0] mode,
                            input logic signed [bdeq_pkg::DATA_W-1:0] value);
        int gap;
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every owed result has come back, then lets
    // the block settle. The first edge gives the predictor time to queue the
    // results of the item accepted just before.
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (queue_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Values lean toward the extremes of the signed range.
    function automatic logic signed [bdeq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bdeq_pkg::MODE_W-1:0] pick_push();
        return $urandom_range(1) ? bdeq_pkg::MODE_PUSH_FRONT : bdeq_pkg::MODE_PUSH_BACK;
    endfunction

    function automatic logic [bdeq_pkg::MODE_W-1:0] pick_pop();
        return $urandom_range(1) ? bdeq_pkg::MODE_POP_FRONT : bdeq_pkg::MODE_POP_BACK;
    endfunction

    // Pops and listings of a fresh, empty queue all report empty.
    task automatic test_empty_queue();
        issue_op(bdeq_pkg::MODE_LIST, VAL_MAX);
        issue_op(bdeq_pkg::MODE_POP_FRONT, VAL_MIN);
        issue_op(bdeq_pkg::MODE_POP_BACK, '1);
    endtask

    // Pushes the extremes of the value range at both ends, lists them and
    // pops from both ends, leaving two entries held.
    task automatic test_extreme_values();
        issue_op(bdeq_pkg::MODE_PUSH_FRONT, VAL_MIN);
        issue_op(bdeq_pkg::MODE_PUSH_BACK, VAL_MAX);
        issue_op(bdeq_pkg::MODE_PUSH_FRONT, '0);
        issue_op(bdeq_pkg::MODE_PUSH_BACK, '1);
        issue_op(bdeq_pkg::MODE_LIST, '0);
        issue_op(bdeq_pkg::MODE_POP_FRONT, '0);
        issue_op(bdeq_pkg::MODE_POP_BACK, '0);
    endtask

    // Modes five to seven must leave the queue alone and give no result.
    task automatic test_unused_modes();
        issue_op(3'd5, pick_value());
        issue_op(3'd6, pick_value());
        issue_op(3'd7, pick_value());
        issue_op(bdeq_pkg::MODE_LIST, '0);
    endtask

    // Fills the ring from both ends, so that the front index wraps, then
    // pushes into the full queue at each end and lists all sixteen entries.
    task automatic test_full_queue();
        for (int k = 0; k < DEPTH - 2; k++) begin
            issue_op(k[0] ? bdeq_pkg::MODE_PUSH_BACK : bdeq_pkg::MODE_PUSH_FRONT,
                     32'sd1 <<< (k * 2));
        end
        issue_op(bdeq_pkg::MODE_PUSH_FRONT, 32'sh5a5a_5a5a);
        issue_op(bdeq_pkg::MODE_PUSH_BACK, 32'sha5a5_a5a5);
        issue_op(bdeq_pkg::MODE_LIST, '0);
        issue_op(bdeq_pkg::MODE_POP_BACK, '0);
        issue_op(bdeq_pkg::MODE_POP_FRONT, '0);
    endtask

    // Random traffic made of bursts: long push runs that usually reach full,
    // long pop runs that usually reach empty, and short runs of any mode.
    // Every burst ends in a listing, so the walk over the ring is checked at
    // many fill levels and front positions.
    task automatic test_random_traffic(input int idle_pct);
        int                          counted;
        int                          len;
        logic [31:0]                 draw;
        logic [bdeq_pkg::MODE_W-1:0] mode;

        sender_idle_pct = idle_pct;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            case ($urandom_range(2))
                0: begin
                    len = $urandom_range(12, 18);
                    repeat (len) issue_op(pick_push(), pick_value());
                end
                1: begin
                    len = $urandom_range(12, 18);
                    repeat (len) issue_op(pick_pop(), pick_value());
                end
                default: begin
                    len = 0;
                    repeat (8) begin
                        draw = $urandom_range(7);
                        mode = draw[bdeq_pkg::MODE_W-1:0];
                        issue_op(mode, pick_value());
                        if (mode <= bdeq_pkg::MODE_POP_BACK) len++;
                    end
                end
            endcase
            issue_op(bdeq_pkg::MODE_LIST, pick_value());
            counted += len + 1;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_mode  <= bdeq_pkg::MODE_LIST;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_extreme_values();
        test_unused_modes();
        test_full_queue();
        wait_until_drained();

        // Phases: no idling, then a busy sender that often goes quiet, then a
        // lighter mix. The receiver cannot stall, so only the sender idles.
        test_random_traffic(0);
        wait_until_drained();
        test_random_traffic(45);
        wait_until_drained();
        test_random_traffic(23);
        wait_until_drained();

        if (mismatches == 0 && queue_results.size() == 0) begin
            $display("bounded_double_ended_queue_core regression: pass");
        end else begin
            $display("bounded_double_ended_queue_core regression: fail");
        end
        $finish;
    end

endmodule
